@@ hw/rtl/csu_pkg.sv @@
// Package for the cosine similarity unit: widths, constants and shared types.
// No dependencies.
`timescale 1ns / 1ps
package csu_pkg;
    localparam int ELEM_W     = 16;
    localparam int ACC_W      = 40;
    localparam int PROD_W     = 80;
    localparam int ROOT_W     = 41;
    localparam int QUO_W      = 54;
    localparam int SIM_W      = 16;
    localparam int MAX_LEN_D  = 64;
    localparam int ELEM_BITS_D = 16;
    localparam int QDEPTH     = 2;
    localparam logic [QUO_W-1:0] ONE_Q14 = QUO_W'(16384);

    typedef struct packed {
        logic signed [ACC_W-1:0] dot;
        logic [ACC_W-1:0]        sqa;
        logic [ACC_W-1:0]        sqb;
    } csu_sums_t;
endpackage

@@ hw/rtl/csu_front.sv @@
// Front end: sign-extends element beats and accumulates dot product and
// sums of squares with saturation. Depends on csu_pkg.
`timescale 1ns / 1ps
module csu_front #(
    parameter int ELEM_BITS = csu_pkg::ELEM_BITS_D
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_fire,
    input  logic signed [csu_pkg::ELEM_W-1:0] elem_a,
    input  logic signed [csu_pkg::ELEM_W-1:0] elem_b,
    input  logic                         last_elem,
    output logic                         sums_valid,
    output csu_pkg::csu_sums_t           sums
);
    import csu_pkg::*;
    localparam int EB = (ELEM_BITS < ELEM_W) ? ELEM_BITS : ELEM_W;

    logic signed [ACC_W-1:0] dot_reg, dot_next;
    logic [ACC_W-1:0]        sqa_reg, sqa_next, sqb_reg, sqb_next;
    logic signed [EB-1:0]    a_e, b_e;
    logic signed [ACC_W+1:0] d_w;
    logic [ACC_W:0]          sa_w, sb_w;
    logic signed [2*EB-1:0]  pab, paa, pbb;

    always_comb
    begin
        a_e = elem_a[EB-1:0];
        b_e = elem_b[EB-1:0];
        pab = a_e * b_e;
        paa = a_e * a_e;
        pbb = b_e * b_e;
        d_w  = (ACC_W+2)'(dot_reg) + (ACC_W+2)'(pab);
        sa_w = {1'b0, sqa_reg} + (ACC_W+1)'($unsigned(paa));
        sb_w = {1'b0, sqb_reg} + (ACC_W+1)'($unsigned(pbb));
        if (d_w > $signed((ACC_W+2)'({1'b0, {(ACC_W-1){1'b1}}})))
            dot_next = {1'b0, {(ACC_W-1){1'b1}}};
        else if (d_w < -((ACC_W+2)'(1) <<< (ACC_W-1)))
            dot_next = {1'b1, {(ACC_W-1){1'b0}}};
        else
            dot_next = d_w[ACC_W-1:0];
        sqa_next = sa_w[ACC_W] ? {ACC_W{1'b1}} : sa_w[ACC_W-1:0];
        sqb_next = sb_w[ACC_W] ? {ACC_W{1'b1}} : sb_w[ACC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
            sqa_reg <= '0;
            sqb_reg <= '0;
            sums_valid <= 1'b0;
            sums <= '0;
        end
        else
        begin
            sums_valid <= in_fire && last_elem;
            if (in_fire)
            begin
                sums.dot <= dot_next;
                sums.sqa <= sqa_next;
                sums.sqb <= sqb_next;
                if (last_elem)
                begin
                    dot_reg <= '0;
                    sqa_reg <= '0;
                    sqb_reg <= '0;
                end
                else
                begin
                    dot_reg <= dot_next;
                    sqa_reg <= sqa_next;
                    sqb_reg <= sqb_next;
                end
            end
        end
    end
endmodule

@@ hw/rtl/csu_queue.sv @@
// Short queue of finished sums between the front and the back end.
// Depends on csu_pkg.
`timescale 1ns / 1ps
module csu_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  csu_pkg::csu_sums_t wr_data,
    input  logic               rd_en,
    output logic               rd_valid,
    output csu_pkg::csu_sums_t rd_data,
    output logic               full,
    output logic               almost_full
);
    import csu_pkg::*;
    csu_sums_t mem [QDEPTH];
    logic [$clog2(QDEPTH)-1:0] wp_reg, rp_reg;
    logic [$clog2(QDEPTH):0]   cnt_reg;

    assign rd_valid    = cnt_reg != '0;
    assign full        = cnt_reg == ($clog2(QDEPTH)+1)'(QDEPTH);
    assign almost_full = cnt_reg >= ($clog2(QDEPTH)+1)'(QDEPTH - 1);
    assign rd_data     = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en) wp_reg <= wp_reg + 1'b1;
            if (rd_en) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (wr_en ? 1'b1 : 1'b0) - (rd_en ? 1'b1 : 1'b0);
        end
    end
endmodule

@@ hw/rtl/csu_back.sv @@
// Back end: product of the sums of squares, bit-serial floor root, restoring
// division and clamp, with a result register. Depends on csu_pkg.
`timescale 1ns / 1ps
module csu_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              job_valid,
    input  csu_pkg::csu_sums_t                job,
    output logic                              job_take,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic signed [csu_pkg::SIM_W-1:0]  similarity,
    output logic                              zero_norm
);
    import csu_pkg::*;
    localparam logic [3:0] S_IDLE = 4'd0, S_M0 = 4'd1, S_M1 = 4'd2, S_M2 = 4'd3,
                           S_M3 = 4'd4, S_SUM = 4'd5, S_ROOT = 4'd6,
                           S_DIV = 4'd7, S_OUT = 4'd8;
    logic [3:0] st_reg;
    logic signed [ACC_W-1:0] dot_reg;
    logic [ACC_W-1:0] sqa_reg, sqb_reg;
    logic [PROD_W-1:0] prod_reg, pp_reg;
    logic [PROD_W-1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [5:0] k_reg;
    logic [QUO_W-1:0] num_reg, quo_reg;
    logic [ROOT_W:0] drem_reg;
    logic neg_reg, zn_reg;
    logic [19:0] xa, xb;
    logic [39:0] pp_w;
    logic [ACC_W:0] mag_w;
    logic [PROD_W-1:0] trial;
    logic [ROOT_W:0] dsh;
    logic [QUO_W-1:0] q_cl;

    assign job_take = (st_reg == S_IDLE) && job_valid;
    assign res_valid = st_reg == S_OUT;

    // Root uses the digit recurrence: rem holds x - r^2, trial 2*r*2^k + 4^k.
    always_comb
    begin
        xa = 20'(sqa_reg >> (20 * (k_reg[1] ? 1 : 0)));
        xb = 20'(sqb_reg >> (20 * (k_reg[0] ? 1 : 0)));
        pp_w = xa * xb;
        mag_w = neg_reg ? -{dot_reg[ACC_W-1], dot_reg} : {dot_reg[ACC_W-1], dot_reg};
        trial = (PROD_W'(root_reg) << (k_reg + 6'd1)) + (PROD_W'(1) << (2 * k_reg));
        dsh = {drem_reg[ROOT_W-1:0], num_reg[QUO_W-1]};
        q_cl = (quo_reg > ONE_Q14) ? ONE_Q14 : quo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            dot_reg <= '0;
            sqa_reg <= '0;
            sqb_reg <= '0;
            prod_reg <= '0;
            pp_reg <= '0;
            rem_reg <= '0;
            root_reg <= '0;
            k_reg <= '0;
            num_reg <= '0;
            quo_reg <= '0;
            drem_reg <= '0;
            neg_reg <= 1'b0;
            zn_reg <= 1'b0;
        end
        else
        begin
            case (st_reg)
                S_IDLE:
                    if (job_valid)
                    begin
                        dot_reg <= job.dot;
                        sqa_reg <= job.sqa;
                        sqb_reg <= job.sqb;
                        prod_reg <= '0;
                        k_reg <= 6'd0;
                        st_reg <= S_M0;
                    end
                S_M0, S_M1, S_M2, S_M3:
                begin
                    // One 20x20 partial product a cycle.
                    pp_reg <= PROD_W'(pp_w) << (20 * ({1'b0, k_reg[1]} + {1'b0, k_reg[0]}));
                    if (st_reg != S_M0) prod_reg <= prod_reg + pp_reg;
                    k_reg <= k_reg + 6'd1;
                    st_reg <= st_reg + 4'd1;
                end
                S_SUM:
                begin
                    // The product stays below 2^80, so the root has at most 40 bits.
                    rem_reg <= prod_reg + pp_reg;
                    root_reg <= '0;
                    k_reg <= 6'd39;
                    zn_reg <= (sqa_reg == '0) || (sqb_reg == '0);
                    neg_reg <= dot_reg < 0;
                    st_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    if (trial <= rem_reg)
                    begin
                        rem_reg <= rem_reg - trial;
                        root_reg <= root_reg | (ROOT_W'(1) << k_reg);
                    end
                    if (k_reg == 6'd0)
                    begin
                        num_reg <= QUO_W'(mag_w) << 14;
                        drem_reg <= '0;
                        quo_reg <= '0;
                        k_reg <= 6'(QUO_W - 1);
                        st_reg <= S_DIV;
                    end
                    else
                        k_reg <= k_reg - 6'd1;
                end
                S_DIV:
                begin
                    if (root_reg == '0) root_reg <= ROOT_W'(1);
                    else
                    begin
                        num_reg <= num_reg << 1;
                        if (dsh >= {1'b0, root_reg})
                        begin
                            drem_reg <= dsh - {1'b0, root_reg};
                            quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
                        end
                        else
                        begin
                            drem_reg <= dsh;
                            quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
                        end
                        if (k_reg == 6'd0) st_reg <= S_OUT;
                        else k_reg <= k_reg - 6'd1;
                    end
                end
                S_OUT:
                    if (!res_stall) st_reg <= S_IDLE;
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        zero_norm = zn_reg;
        if (zn_reg)
            similarity = '0;
        else if (neg_reg)
            similarity = -SIM_W'(q_cl);
        else
            similarity = SIM_W'(q_cl);
    end
endmodule

@@ hw/rtl/cosine_similarity_unit.sv @@
// Top level of the cosine similarity unit: front accumulator, sums queue and
// arithmetic back end. Depends on csu_pkg, csu_front, csu_queue, csu_back.
//
//  channel  signals                          direction
//  input    in_valid in_stall elem_a elem_b last_elem   beat in
//  output   out_valid out_stall similarity zero_norm    beat out
//
// Element beats are taken one a cycle; in_stall rises when the sums queue is
// full, when it has one free slot and finished sums are about to take it, or
// always when MAX_LEN exceeds 256. Each vector then passes through the back
// end in order: taking the sums, the partial-product multiply and sum, the
// bit-serial root, the restoring divider and presenting the result; the back
// end takes no new sums until the last result has left. Reset clears the
// accumulators, the queue and the back-end state. A stalled result holds in
// the back end while the front accumulates until the sums queue fills.
`timescale 1ns / 1ps
module cosine_similarity_unit #(
    parameter int MAX_LEN   = csu_pkg::MAX_LEN_D,
    parameter int ELEM_BITS = csu_pkg::ELEM_BITS_D
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [csu_pkg::ELEM_W-1:0] elem_a,
    input  logic signed [csu_pkg::ELEM_W-1:0] elem_b,
    input  logic                              last_elem,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [csu_pkg::SIM_W-1:0]  similarity,
    output logic                              zero_norm
);
    import csu_pkg::*;

    // The accumulators are 40 bits; the vector length bound only has to fit.
    localparam bit LEN_OK = MAX_LEN <= 256;

    csu_sums_t sums, q_data;
    logic sums_valid, q_valid, q_full, q_afull, take;
    logic in_fire;

    // Keep one queue slot spare for the sums registered in the front.
    assign in_stall = q_full || (sums_valid && q_afull) || !LEN_OK;
    assign in_fire  = in_valid && !in_stall;

    csu_front #(.ELEM_BITS(ELEM_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
        .elem_a(elem_a), .elem_b(elem_b), .last_elem(last_elem),
        .sums_valid(sums_valid), .sums(sums)
    );

    csu_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_en(sums_valid), .wr_data(sums),
        .rd_en(take), .rd_valid(q_valid), .rd_data(q_data), .full(q_full),
        .almost_full(q_afull)
    );

    csu_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(q_valid), .job(q_data),
        .job_take(take), .res_valid(out_valid), .res_stall(out_stall),
        .similarity(similarity), .zero_norm(zero_norm)
    );
endmodule
